[sv/gsa_pkg.sv]
// Shared types, constants and command/status structs of the generational slot allocator.
`timescale 1ns / 1ps

package gsa_pkg;

   localparam int SLOTS = 1024;
   localparam int IDX_W = 10;
   localparam int CNT_W = 11;
   localparam int GEN_W = 16;

   typedef logic [1:0]       opcode_type;
   typedef logic [1:0]       status_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [GEN_W-1:0] gen_type;

   localparam opcode_type OP_CREATE  = 2'd0;
   localparam opcode_type OP_DESTROY = 2'd1;
   localparam opcode_type OP_QUERY   = 2'd2;
   localparam opcode_type OP_TICK    = 2'd3;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_NO_FREE    = 2'd1;
   localparam status_type ST_BAD_HANDLE = 2'd2;
   localparam status_type ST_LIST_FULL  = 2'd3;

   // Per-slot flags kept in one memory word.
   typedef struct packed {
      logic pend;
      logic occ;
   } flag_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic accept;
      logic gen_rd;
      logic walk_step;
      logic fin;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic walk_done;
      logic out_free;
   } stat_type;

endpackage

[sv/gsa_channels.sv]
// Request and response channel interfaces of the generational slot allocator.
`timescale 1ns / 1ps

interface gsa_req_if;
   import gsa_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   idx_type    slot_index;
   gen_type    handle_generation;

   modport source (output valid, output opcode, output slot_index,
                   output handle_generation, input ready);
   modport sink (input valid, input opcode, input slot_index,
                 input handle_generation, output ready);
endinterface

interface gsa_rsp_if;
   import gsa_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   idx_type    granted_index;
   gen_type    granted_generation;
   logic       slot_occupied;
   cnt_type    freed_count;

   modport source (output valid, output status, output granted_index,
                   output granted_generation, output slot_occupied,
                   output freed_count, input ready);
   modport sink (input valid, input status, input granted_index,
                 input granted_generation, input slot_occupied,
                 input freed_count, output ready);
endinterface

[sv/gsa_controller.sv]
// Sequencing state machine of the generational slot allocator.
`timescale 1ns / 1ps

module gsa_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  gsa_pkg::opcode_type req_opcode,
   output logic             req_ready,
   input  logic             csr_wr_en,
   input  gsa_pkg::stat_type stat,
   output gsa_pkg::cmd_type  cmd
);
   import gsa_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CGEN  = 3'd2;
   localparam logic [2:0] S_WALK  = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_ready && req_valid;

   always_comb begin
      cmd.clr_step  = (state_ff == S_CLEAR);
      cmd.accept    = accept;
      cmd.gen_rd    = (state_ff == S_CGEN);
      cmd.walk_step = (state_ff == S_WALK);
      cmd.fin       = (state_ff == S_FIN) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_CREATE) state_in = S_CGEN;
               else if (req_opcode == OP_TICK) state_in = S_WALK;
               else state_in = S_FIN;
            end
         end
         S_CGEN: begin
            state_in = S_FIN;
         end
         S_WALK: begin
            if (stat.walk_done) state_in = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // A slot count write restarts the clearing pass.
      if (csr_wr_en) state_in = S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

endmodule

[sv/gsa_datapath.sv]
// Memories, counters and result register of the generational slot allocator.
`timescale 1ns / 1ps

module gsa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  gsa_pkg::cmd_type     cmd,
   output gsa_pkg::stat_type    stat,
   input  logic                 csr_wr_en,
   input  gsa_pkg::cnt_type     csr_wr_data,
   input  gsa_pkg::opcode_type  req_opcode,
   input  gsa_pkg::idx_type     req_slot_index,
   input  gsa_pkg::gen_type     req_handle_generation,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output gsa_pkg::status_type  rsp_status,
   output gsa_pkg::idx_type     rsp_granted_index,
   output gsa_pkg::gen_type     rsp_granted_generation,
   output logic                 rsp_slot_occupied,
   output gsa_pkg::cnt_type     rsp_freed_count
);
   import gsa_pkg::*;

   localparam cnt_type SLOTS_C = CNT_W'(SLOTS);

   // Memories.
   idx_type  stack_mem [SLOTS];
   gen_type  gen_mem   [SLOTS];
   flag_type flag_mem  [SLOTS];
   idx_type  list_mem  [SLOTS];

   idx_type  stack_rdata_ff;
   gen_type  gen_rdata_ff;
   flag_type flag_rdata_ff;
   idx_type  list_rdata_ff;

   // Control registers.
   cnt_type slot_count_ff, slot_count_in;
   cnt_type top_ff, top_in;
   cnt_type min_top_ff, min_top_in;
   cnt_type pending_count_ff, pending_count_in;
   logic    clear_gen_ff, clear_gen_in;
   idx_type clr_idx_ff, clr_idx_in;
   cnt_type rd_i_ff, rd_i_in;
   logic    wb_valid_ff, wb_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // Request and result payload registers.
   opcode_type req_op_ff;
   idx_type    req_idx_ff;
   gen_type    req_gen_ff;
   idx_type    sel_ff;
   status_type rsp_status_ff;
   idx_type    rsp_index_ff;
   gen_type    rsp_gen_ff;
   logic       rsp_occ_ff;
   cnt_type    rsp_freed_ff;

   // Write and read port controls.
   logic     gen_we, flag_we, stack_we, list_we, list_re, gen_re;
   idx_type  gen_waddr, flag_waddr, gen_raddr;
   gen_type  gen_wdata;
   flag_type flag_wdata;

   cnt_type  top_dec;
   idx_type  sel_in;
   cnt_type  csr_sat;
   logic     in_range, handle_ok, destroy_ok, list_full, top_zero;
   logic     do_create, do_destroy;

   assign top_dec  = top_ff - 1'b1;
   // Stack positions below the lowest top since the last refill still hold
   // their refill value, which is the position itself.
   assign sel_in   = (top_dec < min_top_ff) ? top_dec[IDX_W-1:0] : stack_rdata_ff;
   assign csr_sat  = (csr_wr_data > SLOTS_C) ? SLOTS_C : csr_wr_data;
   assign top_zero = (top_ff == '0);

   assign in_range   = (CNT_W'(req_idx_ff) < slot_count_ff);
   assign handle_ok  = in_range && (gen_rdata_ff == req_gen_ff);
   assign destroy_ok = handle_ok && flag_rdata_ff.occ && !flag_rdata_ff.pend;
   assign list_full  = (pending_count_ff >= SLOTS_C);

   assign do_create  = cmd.fin && (req_op_ff == OP_CREATE) && !top_zero;
   assign do_destroy = cmd.fin && (req_op_ff == OP_DESTROY) && destroy_ok && !list_full;

   assign gen_re    = cmd.accept || cmd.gen_rd;
   assign gen_raddr = cmd.gen_rd ? sel_in : req_slot_index;
   assign list_re   = cmd.walk_step && (rd_i_ff < pending_count_ff);
   assign stack_we  = cmd.walk_step && wb_valid_ff;
   assign list_we   = do_destroy;

   always_comb begin
      gen_we     = 1'b0;
      gen_waddr  = req_idx_ff;
      gen_wdata  = gen_rdata_ff + 1'b1;
      flag_we    = 1'b0;
      flag_waddr = req_idx_ff;
      flag_wdata = '0;
      if (cmd.clr_step) begin
         gen_we     = clear_gen_ff;
         gen_waddr  = clr_idx_ff;
         gen_wdata  = '0;
         flag_we    = 1'b1;
         flag_waddr = clr_idx_ff;
      end else if (do_create) begin
         flag_we        = 1'b1;
         flag_waddr     = sel_ff;
         flag_wdata.occ = 1'b1;
      end else if (do_destroy) begin
         gen_we          = 1'b1;
         flag_we         = 1'b1;
         flag_wdata.occ  = 1'b1;
         flag_wdata.pend = 1'b1;
      end else if (stack_we) begin
         flag_we    = 1'b1;
         flag_waddr = list_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[top_ff[IDX_W-1:0]] <= list_rdata_ff;
      if (cmd.accept) stack_rdata_ff <= stack_mem[top_dec[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
      if (gen_re) gen_rdata_ff <= gen_mem[gen_raddr];
   end

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
      if (cmd.accept) flag_rdata_ff <= flag_mem[req_slot_index];
   end

   always_ff @(posedge clock) begin
      if (list_we) list_mem[pending_count_ff[IDX_W-1:0]] <= req_idx_ff;
      if (list_re) list_rdata_ff <= list_mem[rd_i_ff[IDX_W-1:0]];
   end

   always_comb begin
      slot_count_in    = slot_count_ff;
      top_in           = top_ff;
      min_top_in       = min_top_ff;
      pending_count_in = pending_count_ff;
      clear_gen_in     = clear_gen_ff;
      clr_idx_in       = clr_idx_ff;
      rd_i_in          = rd_i_ff;
      wb_valid_in      = wb_valid_ff;
      rsp_valid_in     = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.fin) rsp_valid_in = 1'b1;

      if (cmd.clr_step) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (stat.clr_last) clear_gen_in = 1'b0;
      end

      if (cmd.accept) begin
         rd_i_in     = '0;
         wb_valid_in = 1'b0;
      end

      if (cmd.walk_step) begin
         wb_valid_in = list_re;
         if (list_re) rd_i_in = rd_i_ff + 1'b1;
         if (stack_we) top_in = top_ff + 1'b1;
      end

      if (do_create) begin
         top_in = top_dec;
         if (top_dec < min_top_ff) min_top_in = top_dec;
      end
      if (do_destroy) pending_count_in = pending_count_ff + 1'b1;
      if (cmd.fin && (req_op_ff == OP_TICK)) pending_count_in = '0;

      if (csr_wr_en) begin
         slot_count_in    = csr_sat;
         top_in           = csr_sat;
         min_top_in       = csr_sat;
         pending_count_in = '0;
         clr_idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff    <= SLOTS_C;
         top_ff           <= SLOTS_C;
         min_top_ff       <= SLOTS_C;
         pending_count_ff <= '0;
         clear_gen_ff     <= 1'b1;
         clr_idx_ff       <= '0;
         rd_i_ff          <= '0;
         wb_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         slot_count_ff    <= slot_count_in;
         top_ff           <= top_in;
         min_top_ff       <= min_top_in;
         pending_count_ff <= pending_count_in;
         clear_gen_ff     <= clear_gen_in;
         clr_idx_ff       <= clr_idx_in;
         rd_i_ff          <= rd_i_in;
         wb_valid_ff      <= wb_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_op_ff  <= req_opcode;
         req_idx_ff <= req_slot_index;
         req_gen_ff <= req_handle_generation;
      end
      if (cmd.gen_rd) sel_ff <= sel_in;
      if (cmd.fin) begin
         rsp_status_ff <= ST_OK;
         rsp_index_ff  <= '0;
         rsp_gen_ff    <= '0;
         rsp_occ_ff    <= 1'b0;
         rsp_freed_ff  <= '0;
         case (req_op_ff)
            OP_CREATE: begin
               if (top_zero) begin
                  rsp_status_ff <= ST_NO_FREE;
               end else begin
                  rsp_index_ff <= sel_ff;
                  rsp_gen_ff   <= gen_rdata_ff;
               end
            end
            OP_DESTROY: begin
               if (!destroy_ok) rsp_status_ff <= ST_BAD_HANDLE;
               else if (list_full) rsp_status_ff <= ST_LIST_FULL;
            end
            OP_QUERY: begin
               rsp_status_ff <= handle_ok ? ST_OK : ST_BAD_HANDLE;
               rsp_occ_ff    <= in_range && flag_rdata_ff.occ;
            end
            OP_TICK: begin
               rsp_freed_ff <= pending_count_ff;
            end
            default: begin
               rsp_status_ff <= ST_OK;
            end
         endcase
      end
   end

   assign stat.clr_last  = (clr_idx_ff == IDX_W'(SLOTS - 1));
   assign stat.walk_done = (rd_i_ff == pending_count_ff) && !wb_valid_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_granted_index      = rsp_index_ff;
   assign rsp_granted_generation = rsp_gen_ff;
   assign rsp_slot_occupied      = rsp_occ_ff;
   assign rsp_freed_count        = rsp_freed_ff;

endmodule

[sv/generational_slot_allocator_top.sv]
// Top level of the generational slot allocator: controller plus datapath.
// The block hands out handles made of a slot index and a generation, checks
// them, and retires slots through a deferred-destroy list. Each request gives
// exactly one response. A create reads the free stack first, and only then
// the slot's generation, because the slot comes from the free-stack read and
// the generation memory has a single read port. The tick walks the destroy
// list one entry per cycle through the list memory's read port, and the
// write-back of the last entry onto the free stack lands in the cycle after
// its read. After reset, and after every write of slot_count, the block runs
// a clearing pass over all 1024 entries of the per-slot flag memory (after
// reset also over the generation memory) with req_chan.ready low; slot_count
// writes are still taken during the pass and restart it. The response sits in
// an output register, so a finished response may wait for rsp_chan.ready
// while the block already accepts and starts the next request.
`timescale 1ns / 1ps

module generational_slot_allocator_top (
   input  logic              clock,
   input  logic              reset,
   gsa_req_if.sink           req_chan,
   gsa_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  gsa_pkg::cnt_type  csr_wr_data
);
   import gsa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller decides what happens each cycle; the datapath owns the
   // free stack, the generation and flag memories and the destroy list.
   gsa_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .csr_wr_en  (csr_wr_en),
      .stat       (stat),
      .cmd        (cmd)
   );

   gsa_datapath u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_opcode             (req_chan.opcode),
      .req_slot_index         (req_chan.slot_index),
      .req_handle_generation  (req_chan.handle_generation),
      .rsp_ready              (rsp_chan.ready),
      .rsp_valid              (rsp_chan.valid),
      .rsp_status             (rsp_chan.status),
      .rsp_granted_index      (rsp_chan.granted_index),
      .rsp_granted_generation (rsp_chan.granted_generation),
      .rsp_slot_occupied      (rsp_chan.slot_occupied),
      .rsp_freed_count        (rsp_chan.freed_count)
   );

endmodule

[sv/gsa_checker.sv]
// Port-level checker of the generational slot allocator and its bind.
`timescale 1ns / 1ps

module gsa_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input gsa_pkg::status_type rsp_status,
   input gsa_pkg::idx_type    rsp_granted_index,
   input logic                csr_wr_en
);
   import gsa_pkg::*;

   // A response that is not taken holds its status and index.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_granted_index))
      else $error("response changed while stalled");

   // Reset starts the clearing pass, so no request is taken right after it.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request port open right after reset");

   // A slot count write starts a new clearing pass.
   a_csr_clear: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_ready)
      else $error("request port open right after slot count write");

   // Only one request is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   // No response can appear in the cycle right after a request is taken.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response faster than the memory read allows");

endmodule

bind generational_slot_allocator_top gsa_checker u_gsa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_granted_index (rsp_chan.granted_index),
   .csr_wr_en         (csr_wr_en)
);

[tb/generational_slot_allocator_top_tb.sv]
// Self-checking testbench of the generational slot allocator top level.
`timescale 1ns / 1ps

module generational_slot_allocator_top_tb;
   import gsa_pkg::*;

   // The run ends here at the latest. A correct run needs far fewer cycles.
   localparam int unsigned CYCLE_LIMIT = 1500000;
   // Bound on a single wait for the block to go quiet.
   localparam int unsigned DRAIN_LIMIT = 400000;
   // The response side holds off this long, twice, to fill the block up.
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned HOLD_FIRST  = 300;
   localparam int unsigned HOLD_SECOND = 1200;
   // Mismatch lines printed before the report goes quiet (counting goes on).
   localparam int unsigned PRINT_CAP   = 40;
   // Slots destroyed during the full sweep.
   localparam int          SWEEP_KILLS = 256;

   // One request as the generator builds it: the payload plus the number of
   // idle cycles the driver waits before it offers the request.
   typedef struct {
      opcode_type  op;
      idx_type     index;
      gen_type     generation;
      int unsigned lead;
   } slot_request_type;

   // One response, field for field as the block returns it.
   typedef struct packed {
      status_type status;
      idx_type    index;
      gen_type    generation;
      logic       occupied;
      cnt_type    freed;
   } slot_reply_type;

   logic clock;
   logic reset = 1'b1;

   // Everything the block sees is driven from these, so all inputs are
   // known from time zero.
   logic       drv_valid = 1'b0;
   opcode_type drv_op = OP_QUERY;
   idx_type    drv_index = '0;
   gen_type    drv_generation = '0;
   logic       rsp_take = 1'b0;
   logic       csr_en = 1'b0;
   cnt_type    csr_data = '0;

   gsa_req_if req_if ();
   gsa_rsp_if rsp_if ();

   assign req_if.valid = drv_valid;
   assign req_if.opcode = drv_op;
   assign req_if.slot_index = drv_index;
   assign req_if.handle_generation = drv_generation;
   assign rsp_if.ready = rsp_take;

   generational_slot_allocator_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_en),
      .csr_wr_data (csr_data)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the allocator. It is advanced when the block accepts a
   // request, so the expected response always follows the real order.
   // ------------------------------------------------------------------
   int          model_limit;
   idx_type     free_slots [SLOTS];
   int          free_depth;
   gen_type     slot_gen [SLOTS];
   bit          slot_live [SLOTS];
   bit          slot_doomed [SLOTS];
   idx_type     doom_list [SLOTS];
   int          doom_depth;

   slot_request_type pending_requests [$];
   slot_reply_type   awaited_replies [$];

   // Driver bookkeeping: a request is first staged (its lead time runs
   // down) and then offered until the block takes it.
   slot_request_type current_req = '{OP_QUERY, '0, '0, 0};
   bit               req_staged;
   bit               req_offer;
   int unsigned      lead_left;

   int unsigned send_gap_cap;
   int unsigned recv_gap_cap;
   int unsigned recv_wait;
   int unsigned rsp_total;
   int unsigned hold_left;
   int unsigned hold_armed;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   // Writing slot_count clamps it to the slot total, refills the free stack
   // with 0 upward (so the highest index comes out first) and forgets every
   // occupied slot and the destroy list. Generations survive.
   function automatic void resize_slot_map(input cnt_type value);
      int k;
      model_limit = (int'(value) > SLOTS) ? SLOTS : int'(value);
      for (k = 0; k < SLOTS; k++) begin
         if (k < model_limit) begin
            free_slots[k] = idx_type'(k);
         end
         slot_live[k] = 1'b0;
         slot_doomed[k] = 1'b0;
      end
      free_depth = model_limit;
      doom_depth = 0;
   endfunction

   // Works out the response to one accepted request and queues it.
   function automatic void compute_allocator_reply(input slot_request_type rq);
      slot_reply_type rp;
      idx_type        s;
      bit             handle_ok;
      int             k;
      rp = '0;
      handle_ok = (int'(rq.index) < model_limit) && (slot_gen[rq.index] == rq.generation);
      case (rq.op)
         OP_CREATE: begin
            if (free_depth == 0) begin
               rp.status = ST_NO_FREE;
            end else begin
               free_depth--;
               s = free_slots[free_depth];
               slot_live[s] = 1'b1;
               rp.index = s;
               rp.generation = slot_gen[s];
            end
         end
         OP_DESTROY: begin
            // A free slot, or one already waiting on the destroy list, is
            // refused before the list is looked at.
            if (!handle_ok || !slot_live[rq.index] || slot_doomed[rq.index]) begin
               rp.status = ST_BAD_HANDLE;
            end else if (doom_depth >= SLOTS) begin
               rp.status = ST_LIST_FULL;
            end else begin
               slot_gen[rq.index] = slot_gen[rq.index] + 1'b1;
               slot_doomed[rq.index] = 1'b1;
               doom_list[doom_depth] = rq.index;
               doom_depth++;
            end
         end
         OP_QUERY: begin
            rp.status = handle_ok ? ST_OK : ST_BAD_HANDLE;
            rp.occupied = (int'(rq.index) < model_limit) ? slot_live[rq.index] : 1'b0;
         end
         default: begin
            // Tick: the destroy list goes back onto the free stack in order.
            for (k = 0; k < doom_depth; k++) begin
               s = doom_list[k];
               slot_live[s] = 1'b0;
               slot_doomed[s] = 1'b0;
               if (free_depth < SLOTS) begin
                  free_slots[free_depth] = s;
                  free_depth++;
               end
            end
            rp.freed = cnt_type'(doom_depth);
            doom_depth = 0;
         end
      endcase
      awaited_replies.insert(awaited_replies.size(), rp);
   endfunction

   // Fields are printed as status/index/generation/occupied/freed.
   task automatic note_mismatch(input string what, input slot_reply_type want,
                                input slot_reply_type seen);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t: %s: want %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                  $time, what, want.status, want.index, want.generation, want.occupied,
                  want.freed, seen.status, seen.index, seen.generation, seen.occupied,
                  seen.freed);
      end
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Clock, reset and the cycle watchdog.
   // ------------------------------------------------------------------
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("generational_slot_allocator_top_tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request driver. The expected response is computed at the edge where
   // the block takes the request. A request with no lead time follows its
   // predecessor without valid ever dropping.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         req_offer = 1'b0;
         req_staged = 1'b0;
         lead_left = 0;
      end else begin
         if (req_offer && req_if.ready) begin
            compute_allocator_reply(current_req);
            req_offer = 1'b0;
         end
         if (!req_offer && !req_staged && pending_requests.size() != 0) begin
            current_req = pending_requests.pop_front();
            lead_left = current_req.lead;
            req_staged = 1'b1;
         end
         if (req_staged) begin
            if (lead_left == 0) begin
               req_offer = 1'b1;
               req_staged = 1'b0;
            end else begin
               lead_left--;
            end
         end
         drv_valid <= req_offer;
         drv_op <= current_req.op;
         drv_index <= current_req.index;
         drv_generation <= current_req.generation;
      end
   end

   // ------------------------------------------------------------------
   // Response monitor. After each response it draws a stall; ready is also
   // held low while the long hold-off runs.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      slot_reply_type seen;
      slot_reply_type want;
      if (reset) begin
         rsp_take <= 1'b0;
         rsp_total <= 0;
         recv_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_take) begin
            seen.status = rsp_if.status;
            seen.index = rsp_if.granted_index;
            seen.generation = rsp_if.granted_generation;
            seen.occupied = rsp_if.slot_occupied;
            seen.freed = rsp_if.freed_count;
            if (awaited_replies.size() == 0) begin
               note_mismatch("response with nothing outstanding", '0, seen);
            end else begin
               want = awaited_replies.pop_front();
               if (seen.status !== want.status || seen.index !== want.index ||
                   seen.generation !== want.generation ||
                   seen.occupied !== want.occupied || seen.freed !== want.freed) begin
                  note_mismatch("response mismatch", want, seen);
               end
            end
            rsp_total <= rsp_total + 1;
            recv_wait = $urandom_range(recv_gap_cap);
         end else if (recv_wait != 0) begin
            recv_wait--;
         end
         rsp_take <= (recv_wait == 0) && (hold_left == 0);
      end
   end

   // Long hold-off on the response side, counted here in cycles. The
   // sender keeps going, so the output register fills and the block has to
   // stall its request side.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_armed <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_armed < 2 &&
                   rsp_total >= ((hold_armed == 0) ? HOLD_FIRST : HOLD_SECOND)) begin
         hold_left <= HOLD_CYCLES;
         hold_armed <= hold_armed + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers. Requests are queued at the falling edge, so the
   // driver never races the generator for the queue.
   // ------------------------------------------------------------------
   task automatic queue_request(input opcode_type op, input idx_type index,
                                input gen_type generation);
      slot_request_type rq;
      do begin
         @(negedge clock);
      end while (pending_requests.size() >= 3);
      rq.op = op;
      rq.index = index;
      rq.generation = generation;
      rq.lead = $urandom_range(send_gap_cap);
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   // Waits until every request is taken and every response has come back.
   task automatic drain_all();
      int unsigned waited;
      waited = 0;
      while ((pending_requests.size() != 0 || req_staged || req_offer ||
              awaited_replies.size() != 0) && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (awaited_replies.size() != 0) begin
         note_mismatch("response never arrived", awaited_replies[0], '0);
      end
   endtask

   // slot_count is only written with the block quiet. The write restarts
   // the clearing pass, which the driver simply waits out.
   task automatic write_slot_count(input cnt_type value);
      drain_all();
      repeat (4) @(posedge clock);
      csr_en <= 1'b1;
      csr_data <= value;
      resize_slot_map(value);
      @(posedge clock);
      csr_en <= 1'b0;
   endtask

   function automatic int unsigned pick_gap_cap();
      case ($urandom_range(2))
         0: return 0;
         1: return 3;
         default: return 15;
      endcase
   endfunction

   function automatic void shuffle_pacing();
      send_gap_cap = pick_gap_cap();
      recv_gap_cap = pick_gap_cap();
   endfunction

   // Finds an occupied slot that is not yet on the destroy list. The shadow
   // state may lag a few requests behind the generator; a stale pick only
   // turns into an invalid handle, which is still checked correctly.
   function automatic bit find_live(output idx_type index);
      int start;
      int k;
      int s;
      start = $urandom_range(SLOTS - 1);
      index = idx_type'(start);
      for (k = 0; k < SLOTS; k++) begin
         s = (start + k) % SLOTS;
         if (slot_live[s] && !slot_doomed[s]) begin
            index = idx_type'(s);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Mostly live handles, some one generation behind, some slots picked
   // within the active range (free, live or waiting on the list), and the rest
   // plain noise over both fields.
   function automatic void pick_handle(output idx_type index, output gen_type generation);
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 80 && find_live(index)) begin
         generation = slot_gen[index];
         if (kind >= 62) begin
            generation = generation - 1'b1;
         end
      end else if (kind < 90 && model_limit != 0) begin
         index = idx_type'($urandom_range(model_limit - 1));
         generation = slot_gen[index];
      end else begin
         index = idx_type'($urandom);
         generation = gen_type'($urandom);
      end
   endfunction

   task automatic random_request(input int unsigned tick_pct);
      opcode_type op;
      idx_type    index;
      gen_type    generation;
      if ($urandom_range(99) < tick_pct) begin
         op = OP_TICK;
      end else begin
         case ($urandom_range(2))
            0: op = OP_CREATE;
            1: op = OP_DESTROY;
            default: op = OP_QUERY;
         endcase
      end
      if (op == OP_DESTROY || op == OP_QUERY) begin
         pick_handle(index, generation);
      end else begin
         // Create and tick ignore the handle fields; fill them with noise.
         index = idx_type'($urandom);
         generation = gen_type'($urandom);
      end
      queue_request(op, index, generation);
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      int         order [SLOTS];
      gen_type    first_gen [SLOTS];
      int         k;
      int         j;
      int         t;
      int         p;
      int         n;
      cnt_type    limit_value;
      int unsigned tick_pct;
      int unsigned phase_items [8];

      for (k = 0; k < SLOTS; k++) begin
         slot_gen[k] = '0;
      end
      resize_slot_map(cnt_type'(SLOTS));
      mismatch_count = 0;
      cycle_count = 0;
      send_gap_cap = 3;
      recv_gap_cap = 3;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset setting: the stack hands out the highest
      // index first, and every generation starts at zero.
      queue_request(OP_CREATE, '0, '0);
      queue_request(OP_CREATE, '1, '1);
      queue_request(OP_QUERY, 10'd1023, 16'd0);
      // Right slot, wrong generation.
      queue_request(OP_QUERY, 10'd1023, 16'hFFFF);
      // A free slot with a matching generation is a valid handle, unoccupied.
      queue_request(OP_QUERY, 10'd0, 16'd0);
      queue_request(OP_DESTROY, 10'd1022, 16'd0);
      // The old handle is dead now, and the new one waits on the list.
      queue_request(OP_DESTROY, 10'd1022, 16'd0);
      queue_request(OP_DESTROY, 10'd1022, 16'd1);
      // The slot stays occupied until the next tick.
      queue_request(OP_QUERY, 10'd1022, 16'd1);
      // Destroy of a slot that was never handed out.
      queue_request(OP_DESTROY, 10'd0, 16'd0);
      queue_request(OP_TICK, '1, '1);
      queue_request(OP_TICK, '0, '0);
      queue_request(OP_CREATE, '0, '0);
      queue_request(OP_DESTROY, 10'd1023, 16'd0);
      queue_request(OP_DESTROY, 10'd1022, 16'd1);
      queue_request(OP_TICK, '0, '0);
      queue_request(OP_QUERY, 10'd1023, 16'd1);

      // No slots at all: nothing can be created and every handle is invalid.
      write_slot_count(cnt_type'(0));
      queue_request(OP_CREATE, '0, '0);
      queue_request(OP_QUERY, 10'd0, 16'd0);
      queue_request(OP_DESTROY, 10'd5, 16'd0);
      queue_request(OP_TICK, '0, '0);

      // One slot: the second create finds the stack empty, and an index past
      // the slot count is invalid whatever its generation.
      write_slot_count(cnt_type'(1));
      queue_request(OP_CREATE, '0, '0);
      queue_request(OP_CREATE, '0, '0);
      queue_request(OP_QUERY, 10'd1023, 16'd1);
      queue_request(OP_DESTROY, 10'd0, 16'd0);
      queue_request(OP_TICK, '0, '0);

      // Full sweep: the largest register value clamps to the slot total and
      // every slot is handed out until the stack runs dry. A random subset is
      // then destroyed and one tick returns it all at once.
      write_slot_count(cnt_type'(11'h7FF));
      for (k = 0; k <= SLOTS; k++) begin
         if (k % 64 == 0) begin
            shuffle_pacing();
         end
         queue_request(OP_CREATE, idx_type'($urandom), gen_type'($urandom));
      end
      for (k = 0; k < SLOTS; k++) begin
         order[k] = k;
      end
      for (k = SLOTS - 1; k > 0; k--) begin
         j = $urandom_range(k);
         t = order[k];
         order[k] = order[j];
         order[j] = t;
      end
      for (k = 0; k < SWEEP_KILLS; k++) begin
         if (k % 64 == 0) begin
            shuffle_pacing();
         end
         // Creates leave generations alone, so the value read here is the
         // one the slot still carries when its destroy is taken.
         first_gen[k] = slot_gen[order[k]];
         queue_request(OP_DESTROY, idx_type'(order[k]), first_gen[k]);
      end
      // A second destroy with the new generation hits a slot on the list.
      queue_request(OP_DESTROY, idx_type'(order[0]), first_gen[0] + 1'b1);
      queue_request(OP_TICK, '0, '0);
      for (k = 0; k < 3; k++) begin
         queue_request(OP_CREATE, '0, '0);
      end

      // Random phases over a spread of slot counts. Small counts keep the
      // stack close to empty; large ones let the destroy list grow long.
      phase_items = '{80, 90, 120, 90, 90, 60, 20, 50};
      for (p = 0; p < 8; p++) begin
         case (p)
            0: limit_value = cnt_type'(2);
            1: limit_value = cnt_type'(7);
            2: limit_value = cnt_type'(SLOTS);
            3: limit_value = cnt_type'(64);
            4: limit_value = cnt_type'($urandom_range(3, SLOTS - 1));
            5: limit_value = cnt_type'(1);
            6: limit_value = cnt_type'(0);
            default: limit_value = cnt_type'(SLOTS + 1);
         endcase
         write_slot_count(limit_value);
         tick_pct = (limit_value <= 8) ? 20 : 10;
         for (n = 0; n < phase_items[p]; n++) begin
            if (n % 60 == 0) begin
               shuffle_pacing();
            end
            random_request(tick_pct);
         end
      end

      // Let everything come back, then watch a little longer for strays.
      drain_all();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("generational_slot_allocator_top_tb passed");
      end else begin
         $display("generational_slot_allocator_top_tb failed");
      end
      $finish;
   end

endmodule
